// ===== src/rrcg_pkg.sv =====
// rrcg_pkg: shared types and constants of the two-rate rotor curve generator
// used by the front, queue, back end and top level; depends on nothing
`timescale 1ns / 1ps

package rrcg_pkg;

  // field and register widths
  localparam int DT_W      = 20;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SCALE_W   = 13;
  localparam int POS_W     = 18;
  localparam int PROD_W    = 36;

  // saturation rails of a coordinate
  localparam int POS_MAX = 131071;
  localparam int POS_MIN = -131072;

  // queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANIM_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_RATIO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTOR_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z     = 3'd5;

  // 1/(2pi) in Q0.28 and the cordic gain in Q30
  localparam logic [25:0]        INV2PI_Q28   = 26'd42722830;
  localparam logic signed [32:0] CORDIC_K_Q30 = 33'sd652032874;

  // arctangent of 2^-i in turns, 2^32 = one turn
  localparam int CORDIC_TAB_LEN = 30;
  localparam logic [31:0] ATAN_TURNS [CORDIC_TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // configuration register set
  typedef struct packed {
    logic                      anim_enable;
    logic [CFG_W-1:0]          time_scale;
    logic [CFG_W-1:0]          rate_ratio;
    logic [CFG_W-1:0]          rotor_gain;
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_z;
  } rrcg_cfg_t;

  // classified tick waiting in the queue
  typedef struct packed {
    logic              hold;
    logic [PROD_W-1:0] prod;
  } rrcg_item_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_LOAD,
    ST_ROTATE,
    ST_TRIG,
    ST_COORD,
    ST_DONE
  } rrcg_state_e;

endpackage

// ===== src/two_rate_rotor_curve_generator_unit.sv =====
// two_rate_rotor_curve_generator_unit: top level with configuration registers
// depends on rrcg_pkg, rrcg_front, rrcg_fifo and rrcg_back
//
//  channel | direction | handshake                  | payload
//  input   | in        | in_valid_i / in_ready_o    | delta_t_i
//  output  | out       | out_valid_o / out_ready_i  | pos_x_o pos_z_o moved_o clipped_o
//  config  | in        | cfg_we_i, no wait          | cfg_idx_i cfg_data_i
//
// in the back end a tick runs the phase multiply steps for both rotors, then, unless
// animation is off, the one-step-per-cycle cordic, the trig rounding and the coordinate sums
// reset clears phases, queue and sequencer and loads the register defaults
// the two-entry queue keeps taking ticks while the back end works or its result waits
// a finished result holds in the output register until taken
`timescale 1ns / 1ps

module two_rate_rotor_curve_generator_unit import rrcg_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int TRIG_BITS  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [DT_W-1:0]          delta_t_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [POS_W-1:0]  pos_x_o,
  output logic signed [POS_W-1:0]  pos_z_o,
  output logic                     moved_o,
  output logic                     clipped_o
);

  rrcg_cfg_t  cfg_q;
  logic       push, full, pop, q_valid;
  rrcg_item_t push_item, pop_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.anim_enable <= 1'b1;
      cfg_q.time_scale  <= 16'd256;
      cfg_q.rate_ratio  <= 16'd9362;
      cfg_q.rotor_gain  <= 16'd8192;
      cfg_q.scale_x     <= '0;
      cfg_q.scale_z     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ANIM_ENABLE: cfg_q.anim_enable <= cfg_data_i[0];
        CFG_TIME_SCALE:  cfg_q.time_scale  <= cfg_data_i;
        CFG_RATE_RATIO:  cfg_q.rate_ratio  <= cfg_data_i;
        CFG_ROTOR_GAIN:  cfg_q.rotor_gain  <= cfg_data_i;
        CFG_SCALE_X:     cfg_q.scale_x     <= $signed(cfg_data_i[SCALE_W-1:0]);
        CFG_SCALE_Z:     cfg_q.scale_z     <= $signed(cfg_data_i[SCALE_W-1:0]);
        default:         cfg_q.anim_enable <= cfg_q.anim_enable;
      endcase
    end
  end

  // intake and classification
  rrcg_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .delta_t_i   (delta_t_i),
    .cfg_i       (cfg_q),
    .full_i      (full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // queue between front and back
  rrcg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  // phase, trig and coordinate engine
  rrcg_back #(
    .PHASE_BITS (PHASE_BITS),
    .TRIG_BITS  (TRIG_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pos_x_o      (pos_x_o),
    .pos_z_o      (pos_z_o),
    .moved_o      (moved_o),
    .clipped_o    (clipped_o)
  );

endmodule

// ===== src/rrcg_front.sv =====
// rrcg_front: takes ticks, scales elapsed time and tags hold or move
// depends on rrcg_pkg
`timescale 1ns / 1ps

module rrcg_front import rrcg_pkg::*; (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DT_W-1:0]  delta_t_i,
  input  rrcg_cfg_t        cfg_i,
  input  logic             full_i,
  output logic             push_o,
  output rrcg_item_t       push_item_o
);

  // accept a transaction whenever the queue has room
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // scaled time in Q.24 and the hold tag
  always_comb begin
    push_item_o.prod = PROD_W'(delta_t_i) * PROD_W'(cfg_i.time_scale);
    push_item_o.hold = !cfg_i.anim_enable;
  end

endmodule

// ===== src/rrcg_fifo.sv =====
// rrcg_fifo: two-entry queue between the front and the back end
// depends on rrcg_pkg
`timescale 1ns / 1ps

module rrcg_fifo import rrcg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rrcg_item_t push_item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output rrcg_item_t pop_item_o
);

  rrcg_item_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== src/rrcg_back.sv =====
// rrcg_back: phase accumulators, cordic and coordinate arithmetic
// sequencer with output register; depends on rrcg_pkg
`timescale 1ns / 1ps

module rrcg_back import rrcg_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int TRIG_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rrcg_cfg_t               cfg_i,
  input  logic                    item_valid_i,
  input  rrcg_item_t              item_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [POS_W-1:0] pos_x_o,
  output logic signed [POS_W-1:0] pos_z_o,
  output logic                    moved_o,
  output logic                    clipped_o
);

  localparam int NIT    = TRIG_BITS + 2;
  localparam int IT_W   = $clog2(NIT);
  localparam int TW     = TRIG_BITS + 2;
  localparam int CW     = 33;
  localparam int WW     = 34;
  localparam int AW     = TRIG_BITS + 38;
  localparam int MACC_W = 63;
  localparam int INC_LO = 52 - PHASE_BITS;

  // sub-steps of the phase increment
  localparam logic [2:0] PS_P_LO  = 3'd0;
  localparam logic [2:0] PS_P_HI  = 3'd1;
  localparam logic [2:0] PS_M_LO  = 3'd2;
  localparam logic [2:0] PS_M_HI  = 3'd3;
  localparam logic [2:0] PS_APPLY = 3'd4;

  // sub-steps of the coordinate sums
  localparam logic [2:0] CS_X_SLOW = 3'd0;
  localparam logic [2:0] CS_X_FAST = 3'd1;
  localparam logic [2:0] CS_Z_SLOW = 3'd2;
  localparam logic [2:0] CS_Z_FAST = 3'd3;

  localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - TRIG_BITS)) - 32'd1);
  localparam logic signed [CW-1:0] QUARTER = 33'sh040000000;
  localparam logic signed [CW-1:0] HALF    = 33'sh080000000;
  localparam logic signed [CW-1:0] TRND    = 33'sd1 <<< (29 - TRIG_BITS);
  localparam logic signed [AW-1:0] CRND    = AW'(1) <<< (15 + TRIG_BITS);
  localparam logic signed [AW-1:0] SAT_HI  = AW'(POS_MAX);
  localparam logic signed [AW-1:0] SAT_LO  = AW'(POS_MIN);

  rrcg_state_e state_q, state_d;

  logic [PROD_W-1:0]      p_q;
  logic                   hold_q;
  logic                   rotor_q;
  logic [2:0]             step_q;
  logic [MACC_W-1:0]      macc_q;
  logic [17:0]            mh_q;
  logic [PHASE_BITS-1:0]  phase_q [2];
  logic signed [CW-1:0]   cx_q [2];
  logic signed [CW-1:0]   cy_q [2];
  logic signed [CW-1:0]   cz_q [2];
  logic                   neg_q [2];
  logic [IT_W-1:0]        it_q;
  logic [19:0]            wf_q;
  logic signed [WW-1:0]   sws_q [2];
  logic signed [WW-1:0]   swf_q [2];
  logic signed [TW-1:0]   trc_q [2];
  logic signed [TW-1:0]   trs_q [2];
  logic signed [AW-1:0]   acc_q [2];

  logic                   out_valid_q, moved_q, clipped_q;
  logic signed [POS_W-1:0] pos_x_q, pos_z_q;

  logic                   out_free;

  // phase increment multiplier
  logic [16:0]            rate_q17;
  logic [18:0]            ma;
  logic [25:0]            mb;
  logic [44:0]            mprod;
  logic [MACC_W-1:0]      mterm;

  // angles and cordic step
  logic signed [CW-1:0]   ang [2];
  logic                   ang_neg [2];
  logic signed [CW-1:0]   nx [2], ny [2], nz [2];
  logic signed [CW-1:0]   tx [2], ty [2];
  logic signed [CW-1:0]   atan_s;

  // weights
  logic [16:0]            ws;
  logic [32:0]            wf_full;
  logic signed [SCALE_W-1:0] wscale;
  logic signed [21:0]     wop;
  logic signed [34:0]     wprod;

  // coordinate multiplier
  logic signed [WW-1:0]   cm_a;
  logic signed [TW-1:0]   cm_b;
  logic signed [WW+TW-1:0] cprod;

  // rounding and saturation
  logic signed [AW-1:0]   rv [2];
  logic signed [POS_W-1:0] sat [2];
  logic                   clip [2];

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == ST_IDLE) && item_valid_i;

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_z_o     = pos_z_q;
  assign moved_o     = moved_q;
  assign clipped_o   = clipped_q;

  // operand selection of the increment multiplier
  always_comb begin
    rate_q17 = rotor_q ? (17'h10000 - {1'b0, cfg_i.rate_ratio}) : {1'b0, cfg_i.rate_ratio};
    ma = '0;
    mb = '0;
    unique case (step_q)
      PS_P_LO: begin
        ma = 19'(p_q[17:0]);
        mb = 26'(rate_q17);
      end
      PS_P_HI: begin
        ma = 19'(p_q[35:18]);
        mb = 26'(rate_q17);
      end
      PS_M_LO: begin
        ma = macc_q[34:16];
        mb = INV2PI_Q28;
      end
      PS_M_HI: begin
        ma = 19'(mh_q);
        mb = INV2PI_Q28;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mprod = 45'(ma) * 45'(mb);
    unique case (step_q)
      PS_P_HI: mterm = MACC_W'(mprod) << 18;
      PS_M_HI: mterm = MACC_W'(mprod) << 19;
      default: mterm = MACC_W'(mprod);
    endcase
  end

  // angle fold and one cordic rotation for each rotor
  always_comb begin
    logic [PHASE_BITS+31:0] ext;
    logic [31:0]            a32;
    atan_s = $signed({1'b0, ATAN_TURNS[5'(it_q)]});
    for (int j = 0; j < 2; j++) begin
      ext = {phase_q[j], 32'b0};
      a32 = ext[PHASE_BITS+31 -: 32] & ANG_MASK;
      ang[j]     = $signed({a32[31], a32});
      ang_neg[j] = 1'b0;
      if (ang[j] > QUARTER) begin
        ang[j]     = ang[j] - HALF;
        ang_neg[j] = 1'b1;
      end else if (ang[j] < -QUARTER) begin
        ang[j]     = ang[j] + HALF;
        ang_neg[j] = 1'b1;
      end
      tx[j] = cx_q[j] >>> it_q;
      ty[j] = cy_q[j] >>> it_q;
      if (cz_q[j] >= 0) begin
        nx[j] = cx_q[j] - ty[j];
        ny[j] = cy_q[j] + tx[j];
        nz[j] = cz_q[j] - atan_s;
      end else begin
        nx[j] = cx_q[j] + ty[j];
        ny[j] = cy_q[j] - tx[j];
        nz[j] = cz_q[j] + atan_s;
      end
    end
  end

  // weight products, one per rotation cycle
  always_comb begin
    ws      = 17'h10000 - {1'b0, cfg_i.rate_ratio};
    wf_full = 33'(cfg_i.rate_ratio) * 33'(cfg_i.rotor_gain) + 33'd2048;
    wscale  = (it_q == IT_W'(1) || it_q == IT_W'(2)) ? cfg_i.scale_x : cfg_i.scale_z;
    if (it_q == IT_W'(1) || it_q == IT_W'(3)) begin
      wop = $signed({5'b0, ws});
    end else begin
      wop = $signed({2'b0, wf_q});
    end
    wprod = 35'(wscale) * 35'(wop);
  end

  // coordinate multiplier
  always_comb begin
    unique case (step_q)
      CS_X_SLOW: begin
        cm_a = sws_q[0];
        cm_b = trc_q[0];
      end
      CS_X_FAST: begin
        cm_a = swf_q[0];
        cm_b = trc_q[1];
      end
      CS_Z_SLOW: begin
        cm_a = sws_q[1];
        cm_b = trs_q[0];
      end
      CS_Z_FAST: begin
        cm_a = swf_q[1];
        cm_b = trs_q[1];
      end
      default: begin
        cm_a = '0;
        cm_b = '0;
      end
    endcase
    cprod = (WW+TW)'(cm_a) * (WW+TW)'(cm_b);
  end

  // round half up and saturate
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      rv[j]   = (acc_q[j] + CRND) >>> (16 + TRIG_BITS);
      clip[j] = 1'b0;
      if (rv[j] > SAT_HI) begin
        sat[j]  = POS_W'(POS_MAX);
        clip[j] = 1'b1;
      end else if (rv[j] < SAT_LO) begin
        sat[j]  = POS_W'(POS_MIN);
        clip[j] = 1'b1;
      end else begin
        sat[j] = rv[j][POS_W-1:0];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = ST_PHASE;
        end
      end
      ST_PHASE: begin
        if (step_q == PS_APPLY && rotor_q) begin
          state_d = hold_q ? ST_DONE : ST_LOAD;
        end
      end
      ST_LOAD:   state_d = ST_ROTATE;
      ST_ROTATE: begin
        if (it_q == IT_W'(NIT - 1)) begin
          state_d = ST_TRIG;
        end
      end
      ST_TRIG:   state_d = ST_COORD;
      ST_COORD: begin
        if (step_q == CS_Z_FAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control counters, phase state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotor_q     <= 1'b0;
      step_q      <= '0;
      it_q        <= '0;
      phase_q[0]  <= '0;
      phase_q[1]  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          rotor_q <= 1'b0;
          step_q  <= PS_P_LO;
        end
        ST_PHASE: begin
          if (step_q == PS_APPLY) begin
            phase_q[rotor_q] <= phase_q[rotor_q] + macc_q[51:INC_LO];
            rotor_q          <= 1'b1;
            step_q           <= PS_P_LO;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_LOAD: begin
          it_q <= '0;
        end
        ST_ROTATE: begin
          it_q <= it_q + IT_W'(1);
        end
        ST_TRIG: begin
          step_q <= CS_X_SLOW;
        end
        ST_COORD: begin
          step_q <= step_q + 3'd1;
        end
        ST_DONE: begin
          step_q <= PS_P_LO;
        end
        default: begin
          step_q <= '0;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          p_q    <= item_i.prod;
          hold_q <= item_i.hold;
        end
      end
      ST_PHASE: begin
        if (step_q == PS_P_LO || step_q == PS_M_LO) begin
          macc_q <= mterm;
        end else if (step_q == PS_P_HI || step_q == PS_M_HI) begin
          macc_q <= macc_q + mterm;
        end
        if (step_q == PS_M_LO) begin
          mh_q <= macc_q[52:35];
        end
      end
      ST_LOAD: begin
        for (int j = 0; j < 2; j++) begin
          cx_q[j]  <= CORDIC_K_Q30;
          cy_q[j]  <= '0;
          cz_q[j]  <= ang[j];
          neg_q[j] <= ang_neg[j];
        end
      end
      ST_ROTATE: begin
        for (int j = 0; j < 2; j++) begin
          cx_q[j] <= nx[j];
          cy_q[j] <= ny[j];
          cz_q[j] <= nz[j];
        end
        if (it_q == IT_W'(0)) begin
          wf_q <= wf_full[31:12];
        end
        if (it_q == IT_W'(1)) sws_q[0] <= WW'(wprod);
        if (it_q == IT_W'(2)) swf_q[0] <= WW'(wprod);
        if (it_q == IT_W'(3)) sws_q[1] <= WW'(wprod);
        if (it_q == IT_W'(4)) swf_q[1] <= WW'(wprod);
      end
      ST_TRIG: begin
        for (int j = 0; j < 2; j++) begin
          trc_q[j] <= TW'(((neg_q[j] ? -cx_q[j] : cx_q[j]) + TRND) >>> (30 - TRIG_BITS));
          trs_q[j] <= TW'(((neg_q[j] ? -cy_q[j] : cy_q[j]) + TRND) >>> (30 - TRIG_BITS));
        end
      end
      ST_COORD: begin
        unique case (step_q)
          CS_X_SLOW: acc_q[0] <= AW'(cprod);
          CS_X_FAST: acc_q[0] <= acc_q[0] + AW'(cprod);
          CS_Z_SLOW: acc_q[1] <= AW'(cprod);
          CS_Z_FAST: acc_q[1] <= acc_q[1] + AW'(cprod);
          default:   acc_q[1] <= acc_q[1];
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          if (hold_q) begin
            pos_x_q   <= '0;
            pos_z_q   <= '0;
            moved_q   <= 1'b0;
            clipped_q <= 1'b0;
          end else begin
            pos_x_q   <= sat[0];
            pos_z_q   <= sat[1];
            moved_q   <= 1'b1;
            clipped_q <= clip[0] || clip[1];
          end
        end
      end
      default: begin
        hold_q <= hold_q;
      end
    endcase
  end

  // a held transaction carries a zero point and no clip
  a_hold_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !moved_q |-> pos_x_q == '0 && pos_z_q == '0 && !clipped_q)
    else $error("held result is not zero");

  // a clip flag comes with a coordinate on a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && clipped_q |-> moved_q &&
      (pos_x_q == POS_W'(POS_MAX) || pos_x_q == POS_W'(POS_MIN) ||
       pos_z_q == POS_W'(POS_MAX) || pos_z_q == POS_W'(POS_MIN)))
    else $error("clip flag without saturated coordinate");

  // a new result only leaves the done state
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside done state");

  // rotation count stays inside the iteration range
  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROTATE |-> {1'b0, it_q} < (IT_W+1)'(NIT))
    else $error("cordic iteration count out of range");

endmodule
